// ----- sv/pvd_pkg.sv -----
// pvd_pkg: shared types, constants and decode functions of the prefix varint decoder
// no dependencies; imported by pvd_front, pvd_back and prefix_varint_decoder_unit
`default_nettype none

package pvd_pkg;

  localparam int VAL_W = 64;
  localparam int LEN_W = 4;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [VAL_W-1:0] val_t;

  typedef enum logic {
    CFG_SIGNED_MODE = 1'b0,
    CFG_WIDE_MODE   = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    ST_OK  = 1'b0,
    ST_ERR = 1'b1
  } status_t;

  typedef struct packed {
    logic signed_mode;
    logic wide_mode;
  } cfg_t;

  // one finished value waiting for the offset stage
  typedef struct packed {
    logic        force_err;
    len_t        len;
    logic [7:0]  hold;
    val_t        acc;
  } job_t;

  localparam logic [31:0] OFF5_32  = 32'h1020_4080;
  localparam logic [31:0] HALF5_32 = 32'h0810_2040;

  function automatic len_t length_of(logic [7:0] b);
    len_t n;
    logic run;
    n   = len_t'(1);
    run = 1'b1;
    for (int i = 7; i >= 0; i--) begin
      if (run && b[i]) begin
        n = n + len_t'(1);
      end else begin
        run = 1'b0;
      end
    end
    return n;
  endfunction

  function automatic logic prefix_ok(len_t len, logic [7:0] b, cfg_t cfg);
    logic ok;
    ok = 1'b1;
    if (!cfg.wide_mode) begin
      if (len > len_t'(5)) begin
        ok = 1'b0;
      end else if (len == len_t'(5)) begin
        if (cfg.signed_mode) begin
          ok = (b[2:0] == 3'b000) || (b[2:0] == 3'b111);
        end else begin
          ok = (b[2:0] == 3'b000);
        end
      end
    end
    return ok;
  endfunction

  function automatic val_t offset_of(len_t len);
    val_t k;
    case (len)
      4'd2:    k = 64'h0000_0000_0000_0080;
      4'd3:    k = 64'h0000_0000_0000_4080;
      4'd4:    k = 64'h0000_0000_0020_4080;
      4'd5:    k = 64'h0000_0000_1020_4080;
      4'd6:    k = 64'h0000_0008_1020_4080;
      4'd7:    k = 64'h0000_0408_1020_4080;
      4'd8:    k = 64'h0002_0408_1020_4080;
      4'd9:    k = 64'h0102_0408_1020_4080;
      default: k = '0;
    endcase
    return k;
  endfunction

  // first-byte payload bits placed above the following bytes
  function automatic val_t payload_of(len_t len, logic [7:0] hold, val_t acc);
    val_t p;
    case (len)
      4'd1:    p = {57'b0, hold[6:0]} | acc;
      4'd2:    p = {50'b0, hold[5:0], 8'b0} | acc;
      4'd3:    p = {43'b0, hold[4:0], 16'b0} | acc;
      4'd4:    p = {36'b0, hold[3:0], 24'b0} | acc;
      4'd5:    p = {29'b0, hold[2:0], 32'b0} | acc;
      4'd6:    p = {22'b0, hold[1:0], 40'b0} | acc;
      4'd7:    p = {15'b0, hold[0], 48'b0} | acc;
      default: p = acc;
    endcase
    return p;
  endfunction

  // sign extension from 7 bits per encoded byte
  function automatic val_t sext_of(len_t len, val_t p);
    val_t s;
    case (len)
      4'd1:    s = {{57{p[6]}}, p[6:0]};
      4'd2:    s = {{50{p[13]}}, p[13:0]};
      4'd3:    s = {{43{p[20]}}, p[20:0]};
      4'd4:    s = {{36{p[27]}}, p[27:0]};
      4'd5:    s = {{29{p[34]}}, p[34:0]};
      4'd6:    s = {{22{p[41]}}, p[41:0]};
      4'd7:    s = {{15{p[48]}}, p[48:0]};
      4'd8:    s = {{8{p[55]}}, p[55:0]};
      default: s = p;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// ----- sv/pvd_front.sv -----
// pvd_front: byte framing, length prefix decode and payload gathering
// depends on pvd_pkg; feeds one job per finished value to pvd_back
`default_nettype none

module pvd_front import pvd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cfg_t       cfg,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       take,
  output logic            job_valid,
  output job_t            job
);

  logic [3:0] bytes_left_r, bytes_left_nxt;
  len_t       total_len_r, total_len_nxt;
  val_t       acc_r, acc_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       job_valid_r, job_valid_nxt;
  job_t       job_r, job_nxt;
  logic       accept;
  logic       done;
  len_t       len1;
  logic       pok;
  val_t       acc_shift;

  assign in_stall  = job_valid_r && !take;
  assign accept    = in_valid && !in_stall;
  assign len1      = length_of(in_data_byte);
  assign pok       = prefix_ok(len1, in_data_byte, cfg);
  assign acc_shift = {acc_r[VAL_W-9:0], in_data_byte};

  always_comb begin
    bytes_left_nxt = bytes_left_r;
    total_len_nxt  = total_len_r;
    acc_nxt        = acc_r;
    hold_nxt       = hold_r;
    done           = 1'b0;
    job_nxt        = job_r;
    if (accept) begin
      if (bytes_left_r == 4'd0) begin
        if (!pok) begin
          done          = 1'b1;
          total_len_nxt = '0;
          job_nxt       = '{force_err: 1'b1, len: len_t'(1), hold: in_data_byte, acc: '0};
        end else if (len1 == len_t'(1)) begin
          done          = 1'b1;
          total_len_nxt = '0;
          job_nxt       = '{force_err: 1'b0, len: len_t'(1), hold: in_data_byte, acc: '0};
        end else begin
          hold_nxt       = in_data_byte;
          acc_nxt        = '0;
          total_len_nxt  = len1;
          bytes_left_nxt = len1 - 4'd1;
        end
      end else begin
        acc_nxt        = acc_shift;
        bytes_left_nxt = bytes_left_r - 4'd1;
        if (bytes_left_r == 4'd1) begin
          done          = 1'b1;
          total_len_nxt = '0;
          job_nxt       = '{force_err: 1'b0, len: total_len_r, hold: hold_r, acc: acc_shift};
        end
      end
    end
    job_valid_nxt = (job_valid_r && !take) || done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_left_r <= '0;
      total_len_r  <= '0;
      job_valid_r  <= 1'b0;
    end else begin
      bytes_left_r <= bytes_left_nxt;
      total_len_r  <= total_len_nxt;
      job_valid_r  <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    hold_r <= hold_nxt;
    job_r  <= job_nxt;
  end

  assign job_valid = job_valid_r;
  assign job       = job_r;

endmodule

`default_nettype wire

// ----- sv/pvd_back.sv -----
// pvd_back: offset add, sign handling and range checks, then the result register
// depends on pvd_pkg; takes jobs from pvd_front
`default_nettype none

module pvd_back import pvd_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire logic    job_valid,
  input  wire job_t    job,
  output logic         take,
  output logic         out_valid,
  input  wire logic    out_stall,
  output val_t         out_decoded_value,
  output logic         out_status,
  output len_t         out_encoded_length
);

  logic        out_valid_r;
  val_t        val_r, val_nxt;
  status_t     status_r, status_nxt;
  len_t        len_r;
  logic        load;
  val_t        p, k, kh, ps, rs;
  logic [64:0] sum65;
  logic [32:0] sum33;
  logic [31:0] a32, r32;
  logic        neg5, narrow5, ok;

  assign load = !out_valid_r || !out_stall;
  assign take = load;

  assign p       = payload_of(job.len, job.hold, job.acc);
  assign k       = offset_of(job.len);
  assign kh      = k >> 1;
  assign ps      = sext_of(job.len, p);
  assign rs      = ps[VAL_W-1] ? ps - kh : ps + kh;
  assign sum65   = {1'b0, p} + {1'b0, k};
  assign a32     = job.acc[31:0];
  assign sum33   = {1'b0, a32} + {1'b0, OFF5_32};
  assign neg5    = (job.hold[2:0] == 3'b111);
  assign r32     = neg5 ? a32 - HALF5_32 : a32 + HALF5_32;
  assign narrow5 = !cfg.wide_mode && (job.len == len_t'(5));

  always_comb begin
    ok      = 1'b1;
    val_nxt = '0;
    if (job.force_err || !prefix_ok(job.len, job.hold, cfg)) begin
      ok = 1'b0;
    end else if (narrow5) begin
      if (cfg.signed_mode) begin
        ok      = (r32[31] == neg5);
        val_nxt = {{32{r32[31]}}, r32};
      end else begin
        ok      = !sum33[32];
        val_nxt = {32'b0, sum33[31:0]};
      end
    end else if (!cfg.signed_mode) begin
      ok      = (job.len != len_t'(9)) || !sum65[64];
      val_nxt = sum65[63:0];
    end else begin
      ok      = (job.len != len_t'(9)) || (rs[VAL_W-1] == ps[VAL_W-1]);
      val_nxt = rs;
    end
    if (!ok) begin
      val_nxt = '0;
    end
    status_nxt = ok ? ST_OK : ST_ERR;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && job_valid) begin
      val_r    <= val_nxt;
      status_r <= status_nxt;
      len_r    <= job.len;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_decoded_value  = val_r;
  assign out_status         = status_r;
  assign out_encoded_length = len_r;

endmodule

`default_nettype wire

// ----- sv/prefix_varint_decoder_unit.sv -----
// prefix_varint_decoder_unit: top level of the prefix-length varint decoder
// depends on pvd_pkg, pvd_front and pvd_back
`default_nettype none

// Takes one byte per cycle while in_stall is low and emits one result per finished
// value, or one error result at the byte that shows the value cannot be represented.
// A byte enters the framing stage, which holds the length state and gathers the
// payload; a finished value moves to a job register and then through the offset
// adders into the result register. Throughput is one byte per cycle while in_stall
// is low; the offset adders sit between job register and result register. The modes
// are read at the first byte of a value and again when its job loads the result register.

module prefix_varint_decoder_unit import pvd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [63:0]     out_decoded_value,
  output logic            out_status,
  output logic [3:0]      out_encoded_length,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_index,
  input  wire logic       cfg_wdata
);

  logic signed_mode_r;
  logic wide_mode_r;
  cfg_t cfg;
  logic job_valid;
  job_t job;
  logic take;

  assign cfg_ready = 1'b1;
  assign cfg       = '{signed_mode: signed_mode_r, wide_mode: wide_mode_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b0;
      wide_mode_r   <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SIGNED_MODE: signed_mode_r <= cfg_wdata;
        CFG_WIDE_MODE:   wide_mode_r   <= cfg_wdata;
      endcase
    end
  end

  pvd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .take         (take),
    .job_valid    (job_valid),
    .job          (job)
  );

  pvd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .job_valid          (job_valid),
    .job                (job),
    .take               (take),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_decoded_value  (out_decoded_value),
    .out_status         (out_status),
    .out_encoded_length (out_encoded_length)
  );

  // a waiting job holds while the result register is blocked
  a_job_hold: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid && !take |=> job_valid && $stable(job))
    else $error("pending job lost or changed");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_decoded_value == 64'd0)
    else $error("error result with nonzero value");

  // length always within one to nine bytes
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_encoded_length != 4'd0 && out_encoded_length <= 4'd9)
    else $error("encoded length out of range");

endmodule

`default_nettype wire
